// ----- rtl/dual_pi_duty_controller_top_defines.svh -----
// assertion macros shared by the duty controller rtl
`ifndef DUAL_PI_DUTY_CONTROLLER_TOP_DEFINES_SVH
`define DUAL_PI_DUTY_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, off during reset
`define DPDC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define DPDC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DPDC_ASSERT_IMP(lbl, ante, cons, msg)
`define DPDC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/dpdc_pkg.sv -----
// shared types and constants for the dual pi duty controller
`timescale 1ns / 1ps

package dpdc_pkg;

	// error sum width
	localparam int SUM_WIDTH = 24;

	// field widths
	localparam int IN_W    = 11;
	localparam int GAIN_W  = 16;
	localparam int DUTY_W  = 7;
	localparam int OFS_W   = 9;
	localparam int IDX_W   = 3;
	localparam int WDATA_W = 16;

	// internal widths
	localparam int ERR_W  = IN_W + 1;
	localparam int TERR_W = IN_W + 2;
	localparam int PROD_W = GAIN_W + 1 + TERR_W;
	localparam int Q_W    = GAIN_W + 1 + SUM_WIDTH + 3;
	localparam int FRAC_W = 8;

	// tail error wrap
	localparam logic signed [TERR_W-1:0] TAIL_WRAP_LO  = TERR_W'(-180);
	localparam logic signed [TERR_W-1:0] TAIL_WRAP_ADD = TERR_W'(360);

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_MAIN_KP       = 3'd0,
		REG_MAIN_KI       = 3'd1,
		REG_TAIL_KP       = 3'd2,
		REG_MAIN_DUTY_MAX = 3'd3,
		REG_MAIN_DUTY_MIN = 3'd4,
		REG_TAIL_DUTY_MAX = 3'd5,
		REG_TAIL_DUTY_MIN = 3'd6,
		REG_TAIL_ERR_OFS  = 3'd7
	} reg_idx_t;

	// register reset values
	localparam logic [GAIN_W-1:0]       RST_MAIN_KP       = 16'd1280;
	localparam logic [GAIN_W-1:0]       RST_MAIN_KI       = 16'd26;
	localparam logic [GAIN_W-1:0]       RST_TAIL_KP       = 16'd640;
	localparam logic [DUTY_W-1:0]       RST_MAIN_DUTY_MAX = 7'd98;
	localparam logic [DUTY_W-1:0]       RST_MAIN_DUTY_MIN = 7'd2;
	localparam logic [DUTY_W-1:0]       RST_TAIL_DUTY_MAX = 7'd85;
	localparam logic [DUTY_W-1:0]       RST_TAIL_DUTY_MIN = 7'd2;
	localparam logic signed [OFS_W-1:0] RST_TAIL_ERR_OFS  = 9'sd17;

	// loop selector codes
	localparam logic LOOP_MAIN = 1'b0;
	localparam logic LOOP_TAIL = 1'b1;

	// configuration register bank
	typedef struct packed {
		logic [GAIN_W-1:0]       main_kp;
		logic [GAIN_W-1:0]       main_ki;
		logic [GAIN_W-1:0]       tail_kp;
		logic [DUTY_W-1:0]       main_duty_max;
		logic [DUTY_W-1:0]       main_duty_min;
		logic [DUTY_W-1:0]       tail_duty_max;
		logic [DUTY_W-1:0]       tail_duty_min;
		logic signed [OFS_W-1:0] tail_error_offset;
	} cfg_t;

endpackage

// ----- rtl/dpdc_if.sv -----
// valid/ready channel interfaces of the duty controller
`timescale 1ns / 1ps

// command item: loop selector, setpoint, measured value
interface dpdc_cmd_if;
	import dpdc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   func;
	logic signed [IN_W-1:0] setpoint;
	logic signed [IN_W-1:0] measured;
	modport source (output valid, output func, output setpoint, output measured, input ready);
	modport sink   (input valid, input func, input setpoint, input measured, output ready);
endinterface

// result item: duty, loop echo, clamp flag
interface dpdc_rsp_if;
	import dpdc_pkg::*;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty;
	logic              loop_sel;
	logic              clamped;
	modport source (output valid, output duty, output loop_sel, output clamped, input ready);
	modport sink   (input valid, input duty, input loop_sel, input clamped, output ready);
endinterface

// configuration write channel
interface dpdc_cfg_if;
	import dpdc_pkg::*;
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   idx;
	logic [WDATA_W-1:0] wdata;
	modport source (output valid, output idx, output wdata, input ready);
	modport sink   (input valid, input idx, input wdata, output ready);
endinterface

// ----- rtl/dual_pi_duty_controller_top.sv -----
// Path: an accepted item passes the input, product and result registers before its result is valid.
// Throughput: one item per cycle while the result is taken; the main error sum is read and updated in
// the product stage, so an item sees the sum left by the unclamped main items ahead of it.
// Each stage holds while the stage after it is full and stalled; bubbles are filled.
// Reset: pipeline emptied, error sum cleared, registers back to their defaults.
`timescale 1ns / 1ps
`include "dual_pi_duty_controller_top_defines.svh"

module dual_pi_duty_controller_top (
	input logic      clk,
	input logic      arst_n,
	dpdc_cmd_if.sink   cmd,
	dpdc_rsp_if.source rsp,
	dpdc_cfg_if.sink   cfg
);
	import dpdc_pkg::*;

	cfg_t regs;

	// stage 1: input register
	logic                   valid_s1;
	logic                   func_s1;
	logic signed [IN_W-1:0] sp_s1;
	logic signed [IN_W-1:0] ms_s1;

	// stage 2: products
	logic                     valid_s2;
	logic                     func_s2;
	logic signed [ERR_W-1:0]  err_s2;
	logic signed [PROD_W-1:0] p_kp_s2;
	logic signed [PROD_W-1:0] p_ki_s2;

	// result register and state
	logic                        out_valid_q;
	logic [DUTY_W-1:0]           duty_q;
	logic                        loop_sel_q;
	logic                        clamped_q;
	logic signed [SUM_WIDTH-1:0] sum_q;

	// handshake
	logic rdy_out, rdy_s2, rdy_s1;
	logic sum_we;

	// stage 1 logic
	logic signed [ERR_W-1:0]  err_m;
	logic signed [TERR_W-1:0] err_t_raw, err_t, err_sel;
	logic signed [GAIN_W:0]   gain_sel;
	logic signed [PROD_W-1:0] p_kp, p_ki;

	// stage 2 logic
	logic signed [Q_W-1:0]       ki_sum, q;
	logic [DUTY_W-1:0]           hi, lo;
	logic signed [Q_W-1:0]       hi_q, lo_q;
	logic                        hit_hi, hit_lo, hit;
	logic [DUTY_W-1:0]           duty_d;
	logic signed [SUM_WIDTH:0]   sum_ext;
	logic signed [SUM_WIDTH-1:0] sum_d;

	dpdc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// stage-by-stage ready
	assign rdy_out   = !out_valid_q || rsp.ready;
	assign rdy_s2    = !valid_s2 || rdy_out;
	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign cmd.ready = rdy_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && rdy_s1) begin
			func_s1 <= cmd.func;
			sp_s1   <= cmd.setpoint;
			ms_s1   <= cmd.measured;
		end
	end

	// errors and gain products
	always_comb begin
		err_m     = ERR_W'(sp_s1) - ERR_W'(ms_s1);
		err_t_raw = TERR_W'(sp_s1) - TERR_W'(ms_s1) + TERR_W'(regs.tail_error_offset);
		err_t     = (err_t_raw < TAIL_WRAP_LO) ? err_t_raw + TAIL_WRAP_ADD : err_t_raw;
		if (func_s1 == LOOP_TAIL) begin
			gain_sel = $signed({1'b0, regs.tail_kp});
			err_sel  = err_t;
		end else begin
			gain_sel = $signed({1'b0, regs.main_kp});
			err_sel  = TERR_W'(err_m);
		end
		p_kp = PROD_W'(gain_sel) * PROD_W'(err_sel);
		p_ki = PROD_W'($signed({1'b0, regs.main_ki})) * PROD_W'(err_m);
	end

	// product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && rdy_s2) begin
			func_s2 <= func_s1;
			err_s2  <= err_m;
			p_kp_s2 <= p_kp;
			p_ki_s2 <= p_ki;
		end
	end

	// drive, clamp and sum update
	always_comb begin
		ki_sum = Q_W'($signed({1'b0, regs.main_ki})) * Q_W'(sum_q);
		if (func_s2 == LOOP_TAIL) begin
			q  = Q_W'(p_kp_s2);
			hi = regs.tail_duty_max;
			lo = regs.tail_duty_min;
		end else begin
			q  = ki_sum + Q_W'(p_kp_s2) + Q_W'(p_ki_s2);
			hi = regs.main_duty_max;
			lo = regs.main_duty_min;
		end
		hi_q   = Q_W'({1'b0, hi, {FRAC_W{1'b0}}});
		lo_q   = Q_W'({1'b0, lo, {FRAC_W{1'b0}}});
		hit_hi = q > hi_q;
		hit_lo = q < lo_q;
		hit    = hit_hi || hit_lo;
		priority if (hit_hi) begin
			duty_d = hi;
		end else if (hit_lo) begin
			duty_d = lo;
		end else begin
			duty_d = q[FRAC_W+DUTY_W-1:FRAC_W];
		end
		// saturating accumulate
		sum_ext = (SUM_WIDTH+1)'(sum_q) + (SUM_WIDTH+1)'(err_s2);
		if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
			sum_d = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
			                           : {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end else begin
			sum_d = sum_ext[SUM_WIDTH-1:0];
		end
	end

	assign sum_we = valid_s2 && rdy_out && (func_s2 == LOOP_MAIN) && !hit;

	// error sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (sum_we) begin
			sum_q <= sum_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && rdy_out) begin
			duty_q     <= duty_d;
			loop_sel_q <= func_s2;
			clamped_q  <= hit;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.duty     = duty_q;
	assign rsp.loop_sel = loop_sel_q;
	assign rsp.clamped  = clamped_q;

	// checks
	`DPDC_ASSERT_NXT(a_sum_hold, !sum_we, $stable(sum_q), "error sum moved without a main item")
	`DPDC_ASSERT_IMP(a_unclamped_pos, valid_s2 && !hit, !q[Q_W-1], "unclamped drive is negative")
	`DPDC_ASSERT_NXT(a_accept_fill, cmd.valid && cmd.ready, valid_s1, "accepted item lost at input")
	`DPDC_ASSERT_NXT(a_s2_hold, valid_s2 && !rdy_out, valid_s2 && $stable(p_kp_s2), "stalled products changed")

endmodule

// ----- rtl/dpdc_cfg_regs.sv -----
// configuration register bank of the duty controller
`timescale 1ns / 1ps

module dpdc_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	dpdc_cfg_if.sink       cfg,
	output dpdc_pkg::cfg_t regs
);
	import dpdc_pkg::*;

	cfg_t regs_q;

	// writes always taken
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.main_kp           <= RST_MAIN_KP;
			regs_q.main_ki           <= RST_MAIN_KI;
			regs_q.tail_kp           <= RST_TAIL_KP;
			regs_q.main_duty_max     <= RST_MAIN_DUTY_MAX;
			regs_q.main_duty_min     <= RST_MAIN_DUTY_MIN;
			regs_q.tail_duty_max     <= RST_TAIL_DUTY_MAX;
			regs_q.tail_duty_min     <= RST_TAIL_DUTY_MIN;
			regs_q.tail_error_offset <= RST_TAIL_ERR_OFS;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.idx))
				REG_MAIN_KP:       regs_q.main_kp           <= cfg.wdata;
				REG_MAIN_KI:       regs_q.main_ki           <= cfg.wdata;
				REG_TAIL_KP:       regs_q.tail_kp           <= cfg.wdata;
				REG_MAIN_DUTY_MAX: regs_q.main_duty_max     <= cfg.wdata[DUTY_W-1:0];
				REG_MAIN_DUTY_MIN: regs_q.main_duty_min     <= cfg.wdata[DUTY_W-1:0];
				REG_TAIL_DUTY_MAX: regs_q.tail_duty_max     <= cfg.wdata[DUTY_W-1:0];
				REG_TAIL_DUTY_MIN: regs_q.tail_duty_min     <= cfg.wdata[DUTY_W-1:0];
				REG_TAIL_ERR_OFS:  regs_q.tail_error_offset <= $signed(cfg.wdata[OFS_W-1:0]);
			endcase
		end
	end

endmodule
